// File: hdl/vfc_pkg.sv
package vfc_pkg;

	typedef logic [2:0] req_code_t;

	localparam req_code_t REQ_LOAD_PROJ = 3'd0;
	localparam req_code_t REQ_LOAD_VIEW = 3'd1;
	localparam req_code_t REQ_BUILD     = 3'd2;
	localparam req_code_t REQ_POINT     = 3'd3;
	localparam req_code_t REQ_SPHERE    = 3'd4;
	localparam req_code_t REQ_BOX       = 3'd5;

	localparam logic [1:0] KIND_POINT  = 2'd0;
	localparam logic [1:0] KIND_SPHERE = 2'd1;
	localparam logic [1:0] KIND_BOX    = 2'd2;

	localparam int NUM_PLANES = 6;
	localparam int ROW_W      = 128;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [3:0]         elem_index;
		logic signed [31:0] elem_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] radius;
		logic signed [31:0] half_x;
		logic signed [31:0] half_y;
		logic signed [31:0] half_z;
	} vfc_req_t;

	typedef struct packed {
		logic       inside_res;
		logic [1:0] query_kind;
	} vfc_rsp_t;

	typedef struct packed {
		logic        en;
		logic        view_sel;
		logic [3:0]  idx;
		logic [31:0] data;
	} vfc_load_t;

	typedef struct packed {
		logic             en;
		logic [2:0]       idx;
		logic [ROW_W-1:0] row;
	} vfc_plane_wr_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MRD,
		B_MMUL,
		B_MACC,
		B_XRD,
		B_XVAL,
		B_SQMUL,
		B_SQACC,
		B_SQRT,
		B_DIVINIT,
		B_DIV,
		B_DIVWR,
		B_PWR
	} vfc_build_state_t;

	typedef enum logic [1:0] {
		Q_IDLE,
		Q_RUN,
		Q_HOLD
	} vfc_query_state_t;

endpackage

// File: hdl/view_frustum_culling_unit.sv
// load request: written into the matrix memory on acceptance, next transaction accepted in the following cycle
// build request: runs the serial multiply-accumulate, the 32-step square root
//   and the bit-serial divider
// query: result in the output register once all six plane rows are processed (rows
//   read one per cycle from the plane memory, three pipeline stages)
// reset clears all control state; matrix and plane memories hold garbage until loaded
module view_frustum_culling_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  vfc_pkg::vfc_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output vfc_pkg::vfc_rsp_t rsp
);
	import vfc_pkg::*;

	logic          accept;
	logic          build_busy, query_busy, query_done, query_take;
	logic          build_start, query_start;
	vfc_load_t     load;
	vfc_plane_wr_t plane_wr;
	vfc_rsp_t      q_result;
	vfc_rsp_t      rsp_q;
	logic          rsp_valid_q;

	assign req_ready   = !build_busy && !query_busy;
	assign accept      = req_valid && req_ready;
	assign build_start = accept && (req.req_type == REQ_BUILD);
	assign query_start = accept && (req.req_type == REQ_POINT ||
		req.req_type == REQ_SPHERE || req.req_type == REQ_BOX);

	always_comb begin
		load.en       = accept && (req.req_type == REQ_LOAD_PROJ ||
			req.req_type == REQ_LOAD_VIEW);
		load.view_sel = (req.req_type == REQ_LOAD_VIEW);
		load.idx      = req.elem_index;
		load.data     = req.elem_value;
	end

	vfc_build #(
		.FRAC_BITS(FRAC_BITS)
	) u_build (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.start   (build_start),
		.busy    (build_busy),
		.plane_wr(plane_wr)
	);

	vfc_query #(
		.FRAC_BITS(FRAC_BITS)
	) u_query (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (query_start),
		.req     (req),
		.plane_wr(plane_wr),
		.busy    (query_busy),
		.done    (query_done),
		.take    (query_take),
		.result  (q_result)
	);

	// output register
	assign query_take = query_done && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (query_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (query_take) begin
			rsp_q <= q_result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hdl/vfc_build.sv
module vfc_build #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  vfc_pkg::vfc_load_t     load,
	input  logic                   start,
	output logic                   busy,
	output vfc_pkg::vfc_plane_wr_t plane_wr
);
	import vfc_pkg::*;

	localparam int DIV_W = 32 + FRAC_BITS;
	localparam int IT_W  = $clog2(DIV_W);
	localparam int ACC_W = 66;

	vfc_build_state_t state_q, state_nxt;

	logic [3:0]      e_q;
	logic [1:0]      k_q;
	logic [2:0]      p_q;
	logic [1:0]      w_q;
	logic [IT_W-1:0] it_q;

	logic [31:0] proj_mem [16];
	logic [31:0] view_mem [16];
	logic [31:0] clip_mem [16];

	logic signed [31:0] proj_rd_q, view_rd_q, clip_a_q, clip_b_q;
	logic [3:0]  mrd_view_addr, mrd_proj_addr, clip_a_addr, clip_b_addr;
	logic        clip_wr_en;
	logic [31:0] clip_wr_data;

	logic signed [ACC_W-1:0] acc_q, acc_nxt, prod_ext, prod_sh;
	logic signed [63:0]      prod_q, mul_p;
	logic signed [31:0]      mul_a, mul_b;
	logic signed [31:0]      v_q [4];
	logic [31:0]             nw_q [4];
	logic [63:0]             sq_q, sq_sum, num_q, res_q, bit_q, trial;
	logic                    sq_ge;
	logic [31:0]             m;
	logic                    neg_q;
	logic [31:0]             rem_q, mag;
	logic [DIV_W-1:0]        quo_q;
	logic [32:0]             rem_sh, rem_diff;
	logic                    div_ge;
	logic [31:0]             qc, word;
	logic signed [32:0]      base_e, oth_e, sum33;
	logic [31:0]             v_sat;
	logic                    minus;

	function automatic logic [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic [31:0] r;
		if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
			r = v[31:0];
		end else begin
			r = v[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		return r;
	endfunction

	// matrix and clip storage
	always_ff @(posedge clk) begin
		if (load.en && !load.view_sel) begin
			proj_mem[load.idx] <= load.data;
		end
		if (load.en && load.view_sel) begin
			view_mem[load.idx] <= load.data;
		end
		proj_rd_q <= proj_mem[mrd_proj_addr];
		view_rd_q <= view_mem[mrd_view_addr];
	end

	always_ff @(posedge clk) begin
		if (clip_wr_en) begin
			clip_mem[e_q] <= clip_wr_data;
		end
		clip_a_q <= clip_mem[clip_a_addr];
		clip_b_q <= clip_mem[clip_b_addr];
	end

	// datapath
	assign mul_a    = (state_q == B_MMUL) ? view_rd_q : v_q[w_q];
	assign mul_b    = (state_q == B_MMUL) ? proj_rd_q : v_q[w_q];
	assign mul_p    = mul_a * mul_b;
	assign prod_ext = ACC_W'(prod_q);
	assign prod_sh  = prod_ext >>> FRAC_BITS;
	assign acc_nxt  = ((k_q == 2'd0) ? '0 : acc_q) + prod_sh;

	assign minus  = (p_q == 3'd0) || (p_q == 3'd3) || (p_q == 3'd4);
	assign base_e = {clip_a_q[31], clip_a_q};
	assign oth_e  = {clip_b_q[31], clip_b_q};
	assign sum33  = minus ? (base_e - oth_e) : (base_e + oth_e);
	assign v_sat  = (sum33[32] == sum33[31]) ? sum33[31:0] :
		(sum33[32] ? 32'h8000_0000 : 32'h7fff_ffff);

	assign sq_sum = ((w_q == 2'd0) ? 64'd0 : sq_q) + prod_q;
	assign trial  = res_q + bit_q;
	assign sq_ge  = num_q >= trial;

	assign m        = res_q[31:0];
	assign mag      = v_q[w_q][31] ? (32'd0 - v_q[w_q]) : v_q[w_q];
	assign rem_sh   = {rem_q, quo_q[DIV_W-1]};
	assign rem_diff = rem_sh - {1'b0, m};
	assign div_ge   = rem_sh >= {1'b0, m};

	always_comb begin
		qc = (quo_q > DIV_W'(33'h0_8000_0000)) ? 32'h8000_0000 : quo_q[31:0];
		if (m == 32'd0) begin
			word = 32'd0;
		end else if (neg_q) begin
			word = 32'd0 - qc;
		end else begin
			word = qc[31] ? 32'h7fff_ffff : qc;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_MMUL: begin
				prod_q <= mul_p;
			end
			B_MACC: begin
				acc_q <= acc_nxt;
			end
			B_XVAL: begin
				v_q[w_q] <= v_sat;
			end
			B_SQMUL: begin
				prod_q <= mul_p;
			end
			B_SQACC: begin
				sq_q <= sq_sum;
				if (w_q == 2'd2) begin
					num_q <= sq_sum;
					res_q <= 64'd0;
					bit_q <= 64'h4000_0000_0000_0000;
				end
			end
			B_SQRT: begin
				if (sq_ge) begin
					num_q <= num_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			B_DIVINIT: begin
				neg_q <= v_q[w_q][31];
				quo_q <= DIV_W'(mag) << FRAC_BITS;
				rem_q <= 32'd0;
			end
			B_DIV: begin
				rem_q <= div_ge ? rem_diff[31:0] : rem_sh[31:0];
				quo_q <= {quo_q[DIV_W-2:0], div_ge};
			end
			B_DIVWR: begin
				nw_q[w_q] <= word;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			e_q     <= '0;
			k_q     <= '0;
			p_q     <= '0;
			w_q     <= '0;
			it_q    <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				B_IDLE: begin
					e_q <= '0;
					k_q <= '0;
					p_q <= '0;
					w_q <= '0;
				end
				B_MACC: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						e_q <= e_q + 4'd1;
					end
				end
				B_XVAL: begin
					w_q <= w_q + 2'd1;
				end
				B_SQACC: begin
					if (w_q == 2'd2) begin
						w_q  <= '0;
						it_q <= '0;
					end else begin
						w_q <= w_q + 2'd1;
					end
				end
				B_SQRT: begin
					it_q <= it_q + 1'b1;
				end
				B_DIVINIT: begin
					it_q <= '0;
				end
				B_DIV: begin
					it_q <= it_q + 1'b1;
				end
				B_DIVWR: begin
					w_q <= w_q + 2'd1;
				end
				B_PWR: begin
					p_q <= p_q + 3'd1;
					w_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			B_IDLE: begin
				if (start) begin
					state_nxt = B_MRD;
				end
			end
			B_MRD: begin
				state_nxt = B_MMUL;
			end
			B_MMUL: begin
				state_nxt = B_MACC;
			end
			B_MACC: begin
				state_nxt = (k_q == 2'd3 && e_q == 4'd15) ? B_XRD : B_MRD;
			end
			B_XRD: begin
				state_nxt = B_XVAL;
			end
			B_XVAL: begin
				state_nxt = (w_q == 2'd3) ? B_SQMUL : B_XRD;
			end
			B_SQMUL: begin
				state_nxt = B_SQACC;
			end
			B_SQACC: begin
				state_nxt = (w_q == 2'd2) ? B_SQRT : B_SQMUL;
			end
			B_SQRT: begin
				if (it_q == IT_W'(31)) begin
					state_nxt = B_DIVINIT;
				end
			end
			B_DIVINIT: begin
				state_nxt = B_DIV;
			end
			B_DIV: begin
				if (it_q == IT_W'(DIV_W - 1)) begin
					state_nxt = B_DIVWR;
				end
			end
			B_DIVWR: begin
				state_nxt = (w_q == 2'd3) ? B_PWR : B_DIVINIT;
			end
			B_PWR: begin
				state_nxt = (p_q == 3'(NUM_PLANES - 1)) ? B_IDLE : B_XRD;
			end
			default: begin
				state_nxt = B_IDLE;
			end
		endcase
	end

	always_comb begin
		busy          = (state_q != B_IDLE);
		mrd_view_addr = {e_q[3:2], k_q};
		mrd_proj_addr = {k_q, e_q[1:0]};
		clip_a_addr   = {w_q, 2'd3};
		clip_b_addr   = {w_q, p_q[2:1]};
		clip_wr_en    = (state_q == B_MACC) && (k_q == 2'd3);
		clip_wr_data  = sat_acc(acc_nxt);
		plane_wr.en   = (state_q == B_PWR);
		plane_wr.idx  = p_q;
		plane_wr.row  = {nw_q[3], nw_q[2], nw_q[1], nw_q[0]};
	end

endmodule

// File: hdl/vfc_query.sv
module vfc_query #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  vfc_pkg::vfc_req_t      req,
	input  vfc_pkg::vfc_plane_wr_t plane_wr,
	output logic                   busy,
	output logic                   done,
	input  logic                   take,
	output vfc_pkg::vfc_rsp_t      result
);
	import vfc_pkg::*;

	localparam int DIST_W = 68;

	vfc_query_state_t state_q, state_nxt;

	logic [ROW_W-1:0] plane_mem [NUM_PLANES];

	logic [2:0] iss_q;
	logic       iss_act;
	logic       vld_s1, vld_s2, vld_s3;
	logic       last_s1, last_s2, last_s3;
	logic       ok_q;

	logic signed [31:0] x_q, y_q, z_q, rad_q, hx_q, hy_q, hz_q;
	logic [1:0]         kind_q;

	logic [ROW_W-1:0]    row_s1;
	logic signed [31:0]  pa, pb, pc;
	logic signed [63:0]  ax_s2, by_s2, cz_s2, ahx_s2, bhy_s2, chz_s2;
	logic signed [31:0]  d_s2;
	logic signed [DIST_W-1:0] base_s3, ext_s3, ext_c, tot;
	logic                pass;

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	assign iss_act = (state_q == Q_RUN) && (iss_q != 3'(NUM_PLANES));

	always_ff @(posedge clk) begin
		if (plane_wr.en) begin
			plane_mem[plane_wr.idx] <= plane_wr.row;
		end
		row_s1 <= plane_mem[iss_q];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= req.pos_x;
			y_q    <= req.pos_y;
			z_q    <= req.pos_z;
			rad_q  <= req.radius;
			hx_q   <= req.half_x;
			hy_q   <= req.half_y;
			hz_q   <= req.half_z;
			kind_q <= 2'(req.req_type - REQ_POINT);
		end
	end

	assign pa = row_s1[31:0];
	assign pb = row_s1[63:32];
	assign pc = row_s1[95:64];

	always_ff @(posedge clk) begin
		ax_s2  <= pa * x_q;
		by_s2  <= pb * y_q;
		cz_s2  <= pc * z_q;
		ahx_s2 <= pa * hx_q;
		bhy_s2 <= pb * hy_q;
		chz_s2 <= pc * hz_q;
		d_s2   <= row_s1[127:96];
	end

	always_comb begin
		case (kind_q)
			KIND_BOX: begin
				ext_c = DIST_W'(abs64(ahx_s2)) + DIST_W'(abs64(bhy_s2)) +
					DIST_W'(abs64(chz_s2));
			end
			KIND_SPHERE: begin
				ext_c = DIST_W'(rad_q) <<< FRAC_BITS;
			end
			default: begin
				ext_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		base_s3 <= DIST_W'(ax_s2) + DIST_W'(by_s2) + DIST_W'(cz_s2) +
			(DIST_W'(d_s2) <<< FRAC_BITS);
		ext_s3  <= ext_c;
	end

	assign tot  = base_s3 + ext_s3;
	assign pass = !tot[DIST_W-1] && (tot != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Q_IDLE;
			iss_q   <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			last_s3 <= 1'b0;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			vld_s1  <= iss_act;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			last_s1 <= iss_act && (iss_q == 3'(NUM_PLANES - 1));
			last_s2 <= last_s1;
			last_s3 <= last_s2;
			if (start) begin
				iss_q <= '0;
				ok_q  <= 1'b1;
			end else begin
				if (iss_act) begin
					iss_q <= iss_q + 3'd1;
				end
				if (vld_s3) begin
					ok_q <= ok_q & pass;
				end
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			Q_IDLE: begin
				if (start) begin
					state_nxt = Q_RUN;
				end
			end
			Q_RUN: begin
				if (vld_s3 && last_s3) begin
					state_nxt = Q_HOLD;
				end
			end
			Q_HOLD: begin
				if (take) begin
					state_nxt = Q_IDLE;
				end
			end
			default: begin
				state_nxt = Q_IDLE;
			end
		endcase
	end

	always_comb begin
		busy              = (state_q != Q_IDLE);
		done              = (state_q == Q_HOLD);
		result.inside_res = ok_q;
		result.query_kind = kind_q;
	end

endmodule

// File: hdl/vfc_checker.sv
module vfc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input vfc_pkg::vfc_req_t req,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input vfc_pkg::vfc_rsp_t rsp
);
	import vfc_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.query_kind != 2'd3)
		else $error("illegal query kind on response");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready &&
		(req.req_type == REQ_LOAD_PROJ || req.req_type == REQ_LOAD_VIEW) |=> req_ready)
		else $error("load transaction stalled the request channel");

	a_build_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type == REQ_BUILD |=> !req_ready)
		else $error("request accepted while build in progress");

endmodule

bind view_frustum_culling_unit vfc_checker u_vfc_checker (.*);
